FILE: sv/hybrid_run_merge_sorter_unit_assert.svh
// Assertion macros for the hybrid run merge sorter.
`ifndef HYBRID_RUN_MERGE_SORTER_UNIT_ASSERT_SVH
`define HYBRID_RUN_MERGE_SORTER_UNIT_ASSERT_SVH

// Same-cycle implication under a synchronous reset.
`define HRMS_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under a synchronous reset.
`define HRMS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/hrms_pkg.sv
// Shared types and constants of the hybrid run merge sorter.
package hrms_pkg;

   localparam int RUN_SIZE_WIDTH = 7;
   localparam logic [RUN_SIZE_WIDTH-1:0] RUN_SIZE_RESET = 7'd32;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RUN_SETUP,
      S_INS_CHECK,
      S_INS_KEY,
      S_INS_CMP,
      S_INS_PUT,
      S_RUN_CHECK,
      S_WIDTH_CHECK,
      S_PASS_CHECK,
      S_MRG_CHECK,
      S_MRG_RD,
      S_MRG_STEP,
      S_CPY_RD,
      S_CPY_WR,
      S_OUT_RD,
      S_OUT_LD
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD,
      DP_RUN_SETUP,
      DP_INS_READ,
      DP_INS_KEY,
      DP_INS_SHIFT,
      DP_INS_PUT,
      DP_RUN_NEXT,
      DP_MRG_INIT,
      DP_PASS_INIT,
      DP_MRG_SETUP,
      DP_PASS_NEXT,
      DP_WIDTH_DBL,
      DP_MRG_READ,
      DP_MRG_STEP,
      DP_CPY_READ,
      DP_CPY_WRITE,
      DP_OUT_INIT,
      DP_OUT_READ,
      DP_OUT_PUSH
   } dp_op_type;

   typedef struct packed {
      logic i_gt_hi;
      logic lo_ge_n;
      logic ins_gt;
      logic pos_gt_lo1;
      logic width_lt_n;
      logic mid_lt_hi;
      logic k_at_hi;
      logic j_last;
      logic out_free;
   } dp_status_type;

endpackage

FILE: sv/hrms_datapath.sv
// Datapath: element buffer, merge scratch, index counters and result register.
module hrms_datapath import hrms_pkg::*; #(
   parameter int MAX_ITEMS  = 64,
   parameter int DATA_WIDTH = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_op_type                 op,
   output dp_status_type             status,
   input  logic                      csr_wr_en,
   input  logic [RUN_SIZE_WIDTH-1:0] csr_wr_data,
   input  logic [DATA_WIDTH-1:0]     in_value,
   output logic [DATA_WIDTH-1:0]     out_value,
   output logic                      out_last,
   output logic                      out_valid,
   input  logic                      out_ready
);

   localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int CW = $clog2(MAX_ITEMS + 1);
   localparam int XW = ((CW + 1 > RUN_SIZE_WIDTH) ? CW + 1 : RUN_SIZE_WIDTH) + 2;

   logic [DATA_WIDTH-1:0] buf_mem [MAX_ITEMS];
   logic [DATA_WIDTH-1:0] scr_mem [MAX_ITEMS];

   logic [RUN_SIZE_WIDTH-1:0] run_size_ff;
   logic [CW-1:0]             count_ff;
   logic [XW-1:0]             lo_ff, hi_ff, i_ff, pos_ff, mid_ff, a_ff, b_ff, k_ff, j_ff;
   logic [XW-1:0]             width_ff;
   logic [DATA_WIDTH-1:0]     key_ff, rda_ff, rdb_ff, srd_ff;
   logic [DATA_WIDTH-1:0]     out_value_ff;
   logic                      out_last_ff, out_valid_ff;

   logic [XW-1:0] n_x, rs_x, hi_run, mid_c, hi_c, two_w, lo_two_w;
   logic          take_left, full;

   logic                  buf_we, rda_en, rdb_en, scr_we, scr_re;
   logic [AW-1:0]         buf_wa, rda_addr, rdb_addr, scr_wa, scr_ra;
   logic [DATA_WIDTH-1:0] buf_wd, scr_wd;

   assign n_x      = XW'(count_ff);
   assign rs_x     = (run_size_ff == '0) ? XW'(1) : XW'(run_size_ff);
   assign hi_run   = (lo_ff + rs_x - XW'(1) > n_x - XW'(1)) ? n_x - XW'(1)
                                                          : lo_ff + rs_x - XW'(1);
   assign two_w    = width_ff << 1;
   assign lo_two_w = lo_ff + two_w;
   assign mid_c    = lo_ff + width_ff - XW'(1);
   assign hi_c     = (lo_two_w - XW'(1) > n_x - XW'(1)) ? n_x - XW'(1) : lo_two_w - XW'(1);
   assign full     = (count_ff == CW'(MAX_ITEMS));
   // left run wins ties; an exhausted side never wins
   assign take_left = (a_ff <= mid_ff) &&
                      ((b_ff > hi_ff) || !($signed(rda_ff) > $signed(rdb_ff)));

   always_comb begin
      status.i_gt_hi    = i_ff > hi_ff;
      status.lo_ge_n    = lo_ff >= n_x;
      status.ins_gt     = $signed(rda_ff) > $signed(key_ff);
      status.pos_gt_lo1 = (pos_ff - XW'(1)) > lo_ff;
      status.width_lt_n = width_ff < n_x;
      status.mid_lt_hi  = mid_ff < hi_ff;
      status.k_at_hi    = k_ff == hi_ff;
      status.j_last     = j_ff == n_x - XW'(1);
      status.out_free   = !out_valid_ff || out_ready;
   end

   always_comb begin
      buf_we   = 1'b0;
      buf_wa   = pos_ff[AW-1:0];
      buf_wd   = key_ff;
      rda_en   = 1'b0;
      rda_addr = i_ff[AW-1:0];
      rdb_en   = 1'b0;
      rdb_addr = b_ff[AW-1:0];
      scr_we   = 1'b0;
      scr_wa   = k_ff[AW-1:0];
      scr_wd   = take_left ? rda_ff : rdb_ff;
      scr_re   = 1'b0;
      scr_ra   = k_ff[AW-1:0];
      unique case (op)
         DP_LOAD: begin
            buf_we = !full;
            buf_wa = count_ff[AW-1:0];
            buf_wd = in_value;
         end
         DP_INS_READ: rda_en = 1'b1;
         DP_INS_KEY: begin
            rda_en   = 1'b1;
            rda_addr = AW'(i_ff - XW'(1));
         end
         DP_INS_SHIFT: begin
            buf_we   = 1'b1;
            buf_wd   = rda_ff;
            rda_en   = 1'b1;
            rda_addr = AW'(pos_ff - XW'(2));
         end
         DP_INS_PUT: buf_we = 1'b1;
         DP_MRG_READ: begin
            rda_en   = 1'b1;
            rda_addr = a_ff[AW-1:0];
            rdb_en   = 1'b1;
         end
         DP_MRG_STEP: scr_we = 1'b1;
         DP_CPY_READ: scr_re = 1'b1;
         DP_CPY_WRITE: begin
            buf_we = 1'b1;
            buf_wa = k_ff[AW-1:0];
            buf_wd = srd_ff;
         end
         DP_OUT_READ: begin
            rda_en   = 1'b1;
            rda_addr = j_ff[AW-1:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (buf_we) buf_mem[buf_wa] <= buf_wd;
      if (rda_en) rda_ff <= buf_mem[rda_addr];
      if (rdb_en) rdb_ff <= buf_mem[rdb_addr];
      if (scr_we) scr_mem[scr_wa] <= scr_wd;
      if (scr_re) srd_ff <= scr_mem[scr_ra];
   end

   always_ff @(posedge clock) begin
      unique case (op)
         DP_RUN_SETUP: begin
            hi_ff <= hi_run;
            i_ff  <= lo_ff + XW'(1);
         end
         DP_INS_KEY: begin
            key_ff <= rda_ff;
            pos_ff <= i_ff;
         end
         DP_INS_SHIFT: pos_ff <= pos_ff - XW'(1);
         DP_INS_PUT:   i_ff   <= i_ff + XW'(1);
         DP_MRG_INIT:  width_ff <= rs_x;
         DP_WIDTH_DBL: width_ff <= two_w;
         DP_MRG_SETUP: begin
            mid_ff <= mid_c;
            hi_ff  <= hi_c;
            a_ff   <= lo_ff;
            b_ff   <= mid_c + XW'(1);
            k_ff   <= lo_ff;
         end
         DP_MRG_STEP: begin
            if (take_left) a_ff <= a_ff + XW'(1);
            else           b_ff <= b_ff + XW'(1);
            k_ff <= (k_ff == hi_ff) ? lo_ff : k_ff + XW'(1);
         end
         DP_CPY_WRITE: k_ff <= k_ff + XW'(1);
         DP_OUT_INIT:  j_ff <= '0;
         DP_OUT_PUSH: begin
            j_ff         <= j_ff + XW'(1);
            out_value_ff <= rda_ff;
            out_last_ff  <= (j_ff == n_x - XW'(1));
         end
         default: ;
      endcase
   end

   // control state: run size, fill count, run base and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         run_size_ff  <= RUN_SIZE_RESET;
         count_ff     <= '0;
         lo_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) run_size_ff <= csr_wr_data;
         unique case (op)
            DP_LOAD: begin
               lo_ff <= '0;
               if (!full) count_ff <= count_ff + CW'(1);
            end
            DP_RUN_NEXT:  lo_ff <= lo_ff + rs_x;
            DP_PASS_INIT: lo_ff <= '0;
            DP_PASS_NEXT: lo_ff <= lo_two_w;
            DP_CPY_WRITE: if (k_ff == hi_ff) lo_ff <= lo_two_w;
            DP_OUT_PUSH:  if (j_ff == n_x - XW'(1)) count_ff <= '0;
            default: ;
         endcase
         if (op == DP_OUT_PUSH)  out_valid_ff <= 1'b1;
         else if (out_ready)     out_valid_ff <= 1'b0;
      end
   end

   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;
   assign out_valid = out_valid_ff;

endmodule

FILE: sv/hrms_controller.sv
// Controller state machine: load, insertion runs, merge passes, drain.
module hrms_controller import hrms_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   input  logic          in_last,
   output logic          in_ready,
   input  dp_status_type status,
   output dp_op_type     op
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      op       = DP_NOP;
      in_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               op = DP_LOAD;
               if (in_last) state_in = S_RUN_SETUP;
            end
         end
         S_RUN_SETUP: begin
            op       = DP_RUN_SETUP;
            state_in = S_INS_CHECK;
         end
         S_INS_CHECK: begin
            if (status.i_gt_hi) begin
               op       = DP_RUN_NEXT;
               state_in = S_RUN_CHECK;
            end else begin
               op       = DP_INS_READ;
               state_in = S_INS_KEY;
            end
         end
         S_INS_KEY: begin
            op       = DP_INS_KEY;
            state_in = S_INS_CMP;
         end
         S_INS_CMP: begin
            if (status.ins_gt) begin
               op       = DP_INS_SHIFT;
               state_in = status.pos_gt_lo1 ? S_INS_CMP : S_INS_PUT;
            end else begin
               op       = DP_INS_PUT;
               state_in = S_INS_CHECK;
            end
         end
         S_INS_PUT: begin
            op       = DP_INS_PUT;
            state_in = S_INS_CHECK;
         end
         S_RUN_CHECK: begin
            if (status.lo_ge_n) begin
               op       = DP_MRG_INIT;
               state_in = S_WIDTH_CHECK;
            end else begin
               op       = DP_RUN_SETUP;
               state_in = S_INS_CHECK;
            end
         end
         S_WIDTH_CHECK: begin
            if (status.width_lt_n) begin
               op       = DP_PASS_INIT;
               state_in = S_PASS_CHECK;
            end else begin
               op       = DP_OUT_INIT;
               state_in = S_OUT_RD;
            end
         end
         S_PASS_CHECK: begin
            if (status.lo_ge_n) begin
               op       = DP_WIDTH_DBL;
               state_in = S_WIDTH_CHECK;
            end else begin
               op       = DP_MRG_SETUP;
               state_in = S_MRG_CHECK;
            end
         end
         S_MRG_CHECK: begin
            // right part empty: skip this merge
            if (status.mid_lt_hi) begin
               op       = DP_MRG_READ;
               state_in = S_MRG_STEP;
            end else begin
               op       = DP_PASS_NEXT;
               state_in = S_PASS_CHECK;
            end
         end
         S_MRG_RD: begin
            op       = DP_MRG_READ;
            state_in = S_MRG_STEP;
         end
         S_MRG_STEP: begin
            op       = DP_MRG_STEP;
            state_in = status.k_at_hi ? S_CPY_RD : S_MRG_RD;
         end
         S_CPY_RD: begin
            op       = DP_CPY_READ;
            state_in = S_CPY_WR;
         end
         S_CPY_WR: begin
            op       = DP_CPY_WRITE;
            state_in = status.k_at_hi ? S_PASS_CHECK : S_CPY_RD;
         end
         S_OUT_RD: begin
            op       = DP_OUT_READ;
            state_in = S_OUT_LD;
         end
         S_OUT_LD: begin
            if (status.out_free) begin
               op       = DP_OUT_PUSH;
               state_in = status.j_last ? S_IDLE : S_OUT_RD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

FILE: sv/hybrid_run_merge_sorter_unit.sv
// Load: one item per cycle while idle. Sort of n items: insertion runs, then merge levels;
// in each merge level every element takes one buffer read pair, one scratch write, one copy back.
// Drain: each result is read from the buffer, then pushed once the result register is free;
// the next set may load while the last result waits. Reset is synchronous, active high: fill
// count and state cleared, run_size back to 32; buffer and scratch memories are not cleared.
`include "hybrid_run_merge_sorter_unit_assert.svh"
module hybrid_run_merge_sorter_unit import hrms_pkg::*; #(
   parameter int MAX_ITEMS  = 64,
   parameter int DATA_WIDTH = 16,
   localparam int TDW = ((DATA_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [TDW-1:0]            req_tdata,   // [DATA_WIDTH-1:0] sample_value
   input  logic                      req_tlast,   // is_last
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [TDW-1:0]            rsp_tdata,   // [DATA_WIDTH-1:0] sorted_value
   output logic                      rsp_tlast,   // is_last_out
   input  logic                      csr_wr_en,
   input  logic [RUN_SIZE_WIDTH-1:0] csr_wr_data // run_size
);

   dp_op_type             op;
   dp_status_type         status;
   logic [DATA_WIDTH-1:0] out_value;

   hrms_controller u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_last  (req_tlast),
      .in_ready (req_tready),
      .status   (status),
      .op       (op)
   );

   hrms_datapath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .op          (op),
      .status      (status),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .in_value    (req_tdata[DATA_WIDTH-1:0]),
      .out_value   (out_value),
      .out_last    (rsp_tlast),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready)
   );

   assign rsp_tdata = TDW'(out_value);

   // input stops only after the item that closes a set
   `HRMS_ASSERT_IMPLY(a_ready_falls_on_last, clock, reset, $fell(req_tready) && $past(!reset), $past(req_tvalid && req_tlast), "input stalled without a closing item")
   // a new result is only loaded while sorting, never while loading
   `HRMS_ASSERT_IMPLY(a_result_not_in_load, clock, reset, $rose(rsp_tvalid) && $past(!reset), !$past(req_tready), "result produced during load")
   // a set closes by leaving the load state at once
   `HRMS_ASSERT_NEXT(a_last_starts_sort, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready, "sort did not start after closing item")

endmodule

FILE: bench/tb_hybrid_run_merge_sorter_unit.sv
// Testbench for the hybrid run merge sorter: directed and random sets against a predictor.
module tb_hybrid_run_merge_sorter_unit import hrms_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SET_CAP = 64;

   typedef struct {
      logic signed [15:0] value;
      logic               last;
   } sorted_entry_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [15:0]               req_tdata = '0;   // [15:0] sample_value
   logic                      req_tlast = 1'b0; // is_last
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [15:0]               rsp_tdata;        // [15:0] sorted_value
   logic                      rsp_tlast;        // is_last_out
   logic                      csr_wr_en = 1'b0;
   logic [RUN_SIZE_WIDTH-1:0] csr_wr_data = '0;

   logic signed [15:0] loaded_set[$];
   sorted_entry_type   sorted_queue[$];
   int                 fail_count = 0;
   int                 items_sent = 0;
   int                 burst_left = 0;
   int                 stall_mode = 0;
   int                 stall_timer = 0;

   hybrid_run_merge_sorter_unit DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #30ms;
      $display("hybrid_run_merge_sorter_unit test failed");
      $finish;
   end

   // Stable ascending sort of the loaded set; run length does not change the order.
   task automatic predict_item(input logic signed [15:0] value, input logic last);
      logic signed [15:0] work[$];
      logic signed [15:0] key;
      int pos;
      sorted_entry_type e;
      if (loaded_set.size() < SET_CAP) loaded_set = {loaded_set, value};
      if (last) begin
         work = loaded_set;
         for (int i = 1; i < work.size(); i++) begin
            key = work[i];
            pos = i;
            while (pos > 0 && work[pos-1] > key) begin
               work[pos] = work[pos-1];
               pos--;
            end
            work[pos] = key;
         end
         foreach (work[i]) begin
            e.value = work[i];
            e.last  = (i == work.size() - 1);
            sorted_queue = {sorted_queue, e};
         end
         loaded_set.delete();
      end
   endtask

   task automatic send_item(input logic [15:0] value, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      predict_item(value, last);
      items_sent++;
   endtask

   task automatic drain_results();
      int guard = 0;
      req_tvalid <= 1'b0;
      while (sorted_queue.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (20) @(posedge clock);
   endtask

   task automatic write_run_size(input logic [RUN_SIZE_WIDTH-1:0] rs);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rs;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 16'(32'h8000 + $urandom_range(0, 3));
         1: return 16'(32'h7fff - $urandom_range(0, 3));
         2: return 16'($urandom_range(0, 7) - 4);
         default: return 16'($urandom());
      endcase
   endfunction

   task automatic send_set(input int n);
      for (int i = 0; i < n; i++) send_item(pick_value(), i == n - 1);
   endtask

   task automatic test_extremes();
      send_item(16'h8000, 1'b1);
      send_item(16'h7fff, 1'b0);
      send_item(16'h8000, 1'b0);
      send_item(16'h0000, 1'b0);
      send_item(16'hffff, 1'b0);
      send_item(16'h0001, 1'b1);
      // ties must keep arrival order; equal values look the same anyway
      for (int i = 0; i < 6; i++) send_item((i % 2) ? 16'h0005 : 16'hfffb, i == 5);
   endtask

   task automatic test_run_lengths();
      logic [RUN_SIZE_WIDTH-1:0] sizes[8] = '{7'd1, 7'd0, 7'd2, 7'd3, 7'd64, 7'd127, 7'd85, 7'd7};
      foreach (sizes[i]) begin
         write_run_size(sizes[i]);
         send_set($urandom_range(5, 13));
      end
   endtask

   task automatic test_buffer_full();
      write_run_size(7'd5);
      for (int i = 0; i < 64; i++) send_item(16'(64 - i), 1'b0);
      send_item(16'h8000, 1'b1);  // dropped, still starts the sort
      send_set(70);               // last sample dropped as well
   endtask

   task automatic test_random();
      logic [RUN_SIZE_WIDTH-1:0] rs;
      while (items_sent < 350) begin
         if ($urandom_range(0, 3) == 0) begin
            rs = ($urandom_range(0, 4) == 0) ? RUN_SIZE_WIDTH'($urandom())
                                             : RUN_SIZE_WIDTH'($urandom_range(1, 16));
            write_run_size(rs);
         end
         send_set(($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(1, 16));
      end
   endtask

   // Result channel stall pattern changes every so often.
   always @(posedge clock) begin
      if (stall_timer == 0) begin
         stall_mode  = $urandom_range(0, 3);
         stall_timer = $urandom_range(20, 300);
      end else begin
         stall_timer--;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= ($urandom_range(0, 3) == 0);
         default: rsp_tready <= (stall_timer % 5 != 0);
      endcase
   end

   always @(posedge clock) begin
      sorted_entry_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_queue.size() == 0) begin
            $display("%0t: unexpected item value %0d last %0b", $time,
                     $signed(rsp_tdata), rsp_tlast);
            fail_count++;
         end else begin
            e = sorted_queue.pop_front();
            if ($signed(rsp_tdata) != e.value || rsp_tlast != e.last) begin
               $display("%0t: expected value %0d last %0b, got value %0d last %0b", $time,
                        e.value, e.last, $signed(rsp_tdata), rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_set(40);          // reset run length of 32
      test_extremes();
      test_run_lengths();
      test_buffer_full();
      test_random();
      write_run_size(7'd32);
      send_set(64);
      drain_results();
      if (sorted_queue.size() == 0 && fail_count == 0) begin
         $display("hybrid_run_merge_sorter_unit test passed");
      end else begin
         $display("hybrid_run_merge_sorter_unit test failed");
      end
      $finish;
   end
endmodule
